>>> src/rdpc_pkg.sv
// Shared types and constants for the radar Doppler point correction unit.
package rdpc_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int XW = 36;
	localparam int CW = 34;
	localparam int TW = 27;

	localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
	localparam logic signed [TW-1:0] TRIG_ONE = 27'sd16777216;

	typedef logic signed [31:0] word_t;
	typedef logic signed [TW-1:0] trig_t;

	typedef enum logic [1:0] {
		CFG_VELOCITY_X   = 2'd0,
		CFG_VELOCITY_Y   = 2'd1,
		CFG_DOPPLER      = 2'd2,
		CFG_NONE         = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		word_t px;
		word_t py;
		logic  zero;
		logic  flip;
	} side_t;

endpackage

>>> src/rdpc_cordic.sv
// Pipelined bearing unit: normalizes (x, y) and replays vectoring as rotation for cos/sin.
module rdpc_cordic
	import rdpc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_vld,
	input  word_t px,
	input  word_t py,
	output logic  out_vld,
	output trig_t cs,
	output trig_t sn,
	output side_t side
);

	localparam int NS = CORDIC_STAGES;

	logic signed [XW-1:0] x_s1, y_s1, x_s2, y_s2;
	side_t side_s1, side_s2;
	logic vld_s1, vld_s2;

	logic signed [XW-1:0] cx_s [0:NS];
	logic signed [XW-1:0] cy_s [0:NS];
	logic signed [CW-1:0] cc_s [0:NS];
	logic signed [CW-1:0] css_s [0:NS];
	side_t cside_s [0:NS];
	logic cvld_s [0:NS];

	// shift both by k while the larger magnitude stays below 2^31
	function automatic logic [2*XW-1:0] norm_step(logic signed [XW-1:0] x,
		logic signed [XW-1:0] y, int k);
		logic [XW-1:0] ax, ay, m;
		logic signed [XW-1:0] nx, ny;
		ax = x[XW-1] ? XW'(-x) : XW'(x);
		ay = y[XW-1] ? XW'(-y) : XW'(y);
		m  = (ax > ay) ? ax : ay;
		nx = x;
		ny = y;
		if (m < (XW'(1) << (31 - k))) begin
			nx = x <<< k;
			ny = y <<< k;
		end
		return {nx, ny};
	endfunction

	logic signed [XW-1:0] x0, y0, xa, ya, xb, yb, xc, yc, xd, yd, xe, ye;

	always_comb begin
		x0 = px[31] ? -XW'(px) : XW'(px);
		y0 = px[31] ? -XW'(py) : XW'(py);
		{xa, ya} = norm_step(x_s1, y_s1, 16);
		{xb, yb} = norm_step(xa, ya, 8);
		{xc, yc} = norm_step(x_s2, y_s2, 4);
		{xd, yd} = norm_step(xc, yc, 2);
		{xe, ye} = norm_step(xd, yd, 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			cvld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			cvld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x0;
			y_s1 <= y0;
			side_s1 <= '{px: px, py: py, zero: (px == '0) && (py == '0), flip: px[31]};
			x_s2 <= xb;
			y_s2 <= yb;
			side_s2 <= side_s1;
			cx_s[0] <= xe;
			cy_s[0] <= ye;
			cc_s[0] <= INV_GAIN;
			css_s[0] <= '0;
			cside_s[0] <= side_s2;
		end
	end

	for (genvar gi = 0; gi < NS; gi++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cvld_s[gi+1] <= 1'b0;
			end else if (en) begin
				cvld_s[gi+1] <= cvld_s[gi];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cside_s[gi+1] <= cside_s[gi];
				if (!cy_s[gi][XW-1]) begin
					cx_s[gi+1]  <= cx_s[gi] + (cy_s[gi] >>> gi);
					cy_s[gi+1]  <= cy_s[gi] - (cx_s[gi] >>> gi);
					cc_s[gi+1]  <= cc_s[gi] - (css_s[gi] >>> gi);
					css_s[gi+1] <= css_s[gi] + (cc_s[gi] >>> gi);
				end else begin
					cx_s[gi+1]  <= cx_s[gi] - (cy_s[gi] >>> gi);
					cy_s[gi+1]  <= cy_s[gi] + (cx_s[gi] >>> gi);
					cc_s[gi+1]  <= cc_s[gi] + (css_s[gi] >>> gi);
					css_s[gi+1] <= css_s[gi] - (cc_s[gi] >>> gi);
				end
			end
		end
	end

	logic signed [CW-1:0] cr, sr;
	trig_t cs_n, sn_n;

	always_comb begin
		cr = (cc_s[NS] + CW'(32)) >>> 6;
		sr = (css_s[NS] + CW'(32)) >>> 6;
		if (cside_s[NS].zero) begin
			cs_n = TRIG_ONE;
			sn_n = '0;
		end else if (cside_s[NS].flip) begin
			cs_n = -trig_t'(cr[TW-1:0]);
			sn_n = -trig_t'(sr[TW-1:0]);
		end else begin
			cs_n = trig_t'(cr[TW-1:0]);
			sn_n = trig_t'(sr[TW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= cvld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs <= cs_n;
			sn <= sn_n;
			side <= cside_s[NS];
		end
	end

endmodule

>>> src/radar_doppler_point_correction_unit.sv
// Radar Doppler point correction unit: bearing, range error and saturated correction.
//
// Input channel (in_valid/in_ready) takes one point (point_x, point_y) per item,
// Q16.16. Output channel (out_valid/out_ready) returns one item per point:
// corrected_x, corrected_y and the saturated flag, in input order.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// velocity_x (0), velocity_y (1) and doppler_factor (2); other indexes are
// ignored. cfg_ready is always high; write only while no point is in flight.
// The path runs through the input capture and normalization registers, the
// CORDIC stages, the cos/sin rounding register, and the multiply/round chain
// and the output register.
// Throughput is one item per cycle. The whole pipeline advances together;
// when the output register holds an item that is not taken, every stage
// holds and in_ready falls, so nothing is dropped or repeated.
// Reset clears all valid bits and the configuration registers to zero; data registers are not reset.
module radar_doppler_point_correction_unit
	import rdpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  word_t       point_x,
	input  word_t       point_y,
	output logic        out_valid,
	input  logic        out_ready,
	output word_t       corrected_x,
	output word_t       corrected_y,
	output logic        saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	word_t vx_q, vy_q, beta_q;
	logic en;

	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q <= '0;
			vy_q <= '0;
			beta_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VELOCITY_X: vx_q <= cfg_data;
				CFG_VELOCITY_Y: vy_q <= cfg_data;
				CFG_DOPPLER:    beta_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic t_vld;
	trig_t t_cs, t_sn;
	side_t t_side;

	rdpc_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(in_valid),
		.px(point_x),
		.py(point_y),
		.out_vld(t_vld),
		.cs(t_cs),
		.sn(t_sn),
		.side(t_side)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [58:0] px_s1, py_s1;
	trig_t cs_s1, sn_s1, cs_s2, sn_s2, cs_s3, sn_s3, cs_s4, sn_s4;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [35:0] vr_s2;
	logic signed [67:0] bp_s3;
	logic signed [43:0] dr_s4;
	logic signed [70:0] mx_s5, my_s5;

	logic signed [59:0] vsum;
	logic signed [43:0] dr_n;
	logic signed [46:0] dx, dy;
	logic signed [47:0] rx, ry;
	word_t ox, oy;
	logic clip_x, clip_y;

	always_comb begin
		vsum = 60'(px_s1) + 60'(py_s1) + 60'sd8388608;
		dr_n = 44'((bp_s3 + 68'sd8388608) >>> 24);
		dx = 47'((mx_s5 + 71'sd8388608) >>> 24);
		dy = 47'((my_s5 + 71'sd8388608) >>> 24);
		rx = 48'(side_s5.px) + 48'(dx);
		ry = 48'(side_s5.py) + 48'(dy);
		clip_x = 1'b1;
		clip_y = 1'b1;
		if (rx > 48'sd2147483647) ox = 32'sh7fffffff;
		else if (rx < -48'sd2147483648) ox = 32'sh80000000;
		else begin
			ox = rx[31:0];
			clip_x = 1'b0;
		end
		if (ry > 48'sd2147483647) oy = 32'sh7fffffff;
		else if (ry < -48'sd2147483648) oy = 32'sh80000000;
		else begin
			oy = ry[31:0];
			clip_y = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= t_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= vx_q * t_cs;
			py_s1 <= vy_q * t_sn;
			cs_s1 <= t_cs;
			sn_s1 <= t_sn;
			side_s1 <= t_side;

			vr_s2 <= 36'(vsum >>> 24);
			cs_s2 <= cs_s1;
			sn_s2 <= sn_s1;
			side_s2 <= side_s1;

			bp_s3 <= beta_q * vr_s2;
			cs_s3 <= cs_s2;
			sn_s3 <= sn_s2;
			side_s3 <= side_s2;

			dr_s4 <= dr_n;
			cs_s4 <= cs_s3;
			sn_s4 <= sn_s3;
			side_s4 <= side_s3;

			mx_s5 <= dr_s4 * cs_s4;
			my_s5 <= dr_s4 * sn_s4;
			side_s5 <= side_s4;

			corrected_x <= ox;
			corrected_y <= oy;
			saturated <= clip_x || clip_y;
		end
	end

endmodule

>>> src/rdpc_checker.sv
// Port-level checks for the radar Doppler point correction unit, bound to the top level.
module rdpc_checker
	import rdpc_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t corrected_x,
	input word_t corrected_y,
	input logic  saturated,
	input logic  cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(corrected_x)
			&& $stable(corrected_y) && $stable(saturated))
		else $error("output item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			corrected_x == 32'sh7fffffff || corrected_x == 32'sh80000000
			|| corrected_y == 32'sh7fffffff || corrected_y == 32'sh80000000)
		else $error("saturated flag without a clipped output");

endmodule

bind radar_doppler_point_correction_unit rdpc_checker u_rdpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.corrected_x(corrected_x),
	.corrected_y(corrected_y),
	.saturated(saturated),
	.cfg_ready(cfg_ready)
);

>>> bench/rdpc_checker.sv
// Checker for the radar Doppler point correction unit: predicts each point and compares results.
module rdpc_scoreboard
	import rdpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  word_t       point_x,
	input  word_t       point_y,
	input  logic        out_valid,
	input  logic        out_ready,
	input  word_t       corrected_x,
	input  word_t       corrected_y,
	input  logic        saturated,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          clipped
);

	typedef struct {
		word_t cx;
		word_t cy;
		logic  sat;
	} corr_t;

	localparam longint HALF_Q24 = longint'(1) << 23;
	localparam longint NORM_MIN = longint'(1) << 30;

	longint vel_x, vel_y, beta;
	corr_t  corr_q[$];

	function automatic longint clamp32(longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic corr_t correct_point(word_t px, word_t py);
		longint x, y, c, s, nx, ny, nc, ns, cs, sn, vr, dr, dx, dy, ay;
		logic flip;
		logic sat;
		corr_t r;
		sat = 1'b0;
		if (px == 0 && py == 0) begin
			cs = longint'(1) << 24;
			sn = 0;
		end else begin
			x = px;
			y = py;
			c = longint'(INV_GAIN);
			s = 0;
			flip = 1'b0;
			if (x < 0) begin
				x = -x;
				y = -y;
				flip = 1'b1;
			end
			forever begin
				ay = (y < 0) ? -y : y;
				if (x >= NORM_MIN || ay >= NORM_MIN)
					break;
				x = x * 2;
				y = y * 2;
			end
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					nc = c - (s >>> i);
					ns = s + (c >>> i);
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					nc = c + (s >>> i);
					ns = s - (c >>> i);
				end
				x = nx;
				y = ny;
				c = nc;
				s = ns;
			end
			cs = (c + 32) >>> 6;
			sn = (s + 32) >>> 6;
			if (flip) begin
				cs = -cs;
				sn = -sn;
			end
		end
		vr = (vel_x * cs + vel_y * sn + HALF_Q24) >>> 24;
		dr = (beta * vr + HALF_Q24) >>> 24;
		dx = (dr * cs + HALF_Q24) >>> 24;
		dy = (dr * sn + HALF_Q24) >>> 24;
		r.cx = word_t'(clamp32(longint'(px) + dx, sat));
		r.cy = word_t'(clamp32(longint'(py) + dy, sat));
		r.sat = sat;
		return r;
	endfunction

	assign pending = corr_q.size();

	always @(posedge clk or negedge arst_n) begin
		corr_t e;
		if (!arst_n) begin
			vel_x = 0;
			vel_y = 0;
			beta = 0;
			corr_q.delete();
			errors = 0;
			clipped = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_VELOCITY_X: vel_x = longint'(word_t'(cfg_data));
					CFG_VELOCITY_Y: vel_y = longint'(word_t'(cfg_data));
					CFG_DOPPLER:    beta = longint'(word_t'(cfg_data));
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (corr_q.size() == 0) begin
					$error("result with no point outstanding");
					errors++;
				end else begin
					e = corr_q.pop_front();
					if (e.sat)
						clipped++;
					if (corrected_x !== e.cx) begin
						$error("corrected_x expected %0d actual %0d", e.cx, corrected_x);
						errors++;
					end
					if (corrected_y !== e.cy) begin
						$error("corrected_y expected %0d actual %0d", e.cy, corrected_y);
						errors++;
					end
					if (saturated !== e.sat) begin
						$error("saturated expected %0b actual %0b", e.sat, saturated);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				corr_q.insert(corr_q.size(), correct_point(point_x, point_y));
		end
	end

endmodule

>>> bench/tb.sv
// Testbench top for the radar Doppler point correction unit: stimulus, stalls and verdict.
module tb;
	import rdpc_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	word_t       point_x, point_y;
	logic        out_valid;
	logic        out_ready = 1'b0;
	word_t       corrected_x, corrected_y;
	logic        saturated;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors, pending, clipped;
	int          burst_left;
	int          sent;
	int          idle_cycles = 0;
	int          stall_mode = 0;
	int          stall_cnt = 0;

	radar_doppler_point_correction_unit uut (.*);

	rdpc_scoreboard chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_cnt <= $urandom_range(20, 300);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			2: out_ready <= ($urandom_range(0, 4) == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("radar_doppler_point_correction_unit regression: fail");
			$finish;
		end
	end

	// Valid stays up across a burst; the next call replaces the payload.
	task automatic send_point(input word_t x, input word_t y);
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Valid stays up across back-to-back writes; setup drops it after the last one.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic setup(input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] b);
		drain();
		write_reg(CFG_VELOCITY_X, vx);
		write_reg(CFG_VELOCITY_Y, vy);
		write_reg(CFG_DOPPLER, b);
		write_reg(CFG_NONE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic directed_points();
		send_point(0, 0);
		send_point(32'sh7fffffff, 0);
		send_point(32'sh80000000, 0);
		send_point(0, 32'sh7fffffff);
		send_point(0, 32'sh80000000);
		send_point(32'sh7fffffff, 32'sh7fffffff);
		send_point(32'sh80000000, 32'sh80000000);
		send_point(32'sh80000000, 32'sh7fffffff);
		send_point(32'sh7fffffff, 32'sh80000000);
		send_point(1, 0);
		send_point(-1, 0);
		send_point(0, 1);
		send_point(0, -1);
		send_point(-1, -1);
		send_point(32'sh00010000, 32'sh00010000);
		send_point(-32'sh00640000, 32'sh00320000);
	endtask

	task automatic random_points(input int n);
		word_t x, y;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 4))
				0: begin
					x = $urandom;
					y = $urandom;
				end
				1: begin
					x = $urandom_range(0, 32'h00ffffff) - 32'h00800000;
					y = $urandom_range(0, 32'h00ffffff) - 32'h00800000;
				end
				2: begin
					x = $urandom_range(0, 15) - 8;
					y = $urandom_range(0, 15) - 8;
				end
				3: begin
					x = ($urandom_range(0, 1) == 1) ? $urandom : 0;
					y = (x == 0) ? $urandom : 0;
				end
				default: begin
					x = $urandom_range(0, 32'h0fffffff) - 32'h08000000;
					y = $urandom_range(0, 32'h0fffffff) - 32'h08000000;
				end
			endcase
			send_point(x, y);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_VELOCITY_X;
		cfg_data = '0;
		burst_left = 0;
		sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero velocity and beta
		directed_points();
		random_points(150);

		setup(32'h000a0000, 32'hfffe0000, 32'h01000000);
		directed_points();
		random_points(250);

		setup(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		directed_points();
		random_points(200);

		setup(32'h80000000, 32'h7fffffff, 32'h80000000);
		random_points(200);

		for (int p = 0; p < 4; p++) begin
			setup($urandom_range(0, 32'h01ffffff) - 32'h01000000,
				$urandom_range(0, 32'h01ffffff) - 32'h01000000,
				$urandom_range(0, 32'h07ffffff) - 32'h04000000);
			random_points(110);
		end

		setup($urandom, $urandom, $urandom);
		random_points(120);

		drain();
		$display("covered %0d points over 9 register settings, %0d results clipped",
			sent, clipped);
		if (errors == 0 && pending == 0)
			$display("radar_doppler_point_correction_unit regression: pass");
		else
			$display("radar_doppler_point_correction_unit regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
src/rdpc_pkg.sv
src/rdpc_cordic.sv
src/radar_doppler_point_correction_unit.sv
src/rdpc_checker.sv
bench/rdpc_checker.sv
bench/tb.sv
